/* hw/rtl/tdf_pkg.sv */
// ----------------------------------------------------------------------------
// tdf_pkg: shared types, constants and microcode for the factorizer
// Holds the value width, the control word layout and the read-only program
// that sequences the trial-division datapath.
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int VALUE_BITS = 32;
  localparam int PRIME_BITS = 32;
  localparam int EXP_BITS   = 5;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
  localparam int E_BITS     = $clog2(VALUE_BITS + 1);
  localparam int UPC_BITS   = 5;

  typedef logic [UPC_BITS-1:0] upc_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,       // take the input value, clear the pending factor
    OP_HALVE,      // shift the cofactor right, count the exponent of two
    OP_PUSH2,      // queue (2, e)
    OP_SET3,       // first odd trial divisor, clear exponent
    OP_DIV,        // start cofactor / divisor
    OP_STEPD,      // next odd divisor
    OP_DIVOUT,     // keep the quotient, count, divide again
    OP_PUSHD,      // queue (d, e), next odd divisor
    OP_PUSHREM,    // queue (cofactor, 1)
    OP_FLUSH,      // send the pending factor as the last one
    OP_EMIT_ZERO   // send (0, 0) as the only, last result
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NOSTART,
    C_LT2,
    C_ODD,
    C_BIT1_CLR,
    C_REM_LE1,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_R_Z
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Program labels
  localparam upc_t L_IDLE   = 5'd0;
  localparam upc_t L_SMALL  = 5'd1;
  localparam upc_t L_PARITY = 5'd2;
  localparam upc_t L_HALVE  = 5'd3;
  localparam upc_t L_PUSH2  = 5'd4;
  localparam upc_t L_SET3   = 5'd5;
  localparam upc_t L_TRIAL  = 5'd6;
  localparam upc_t L_TWAIT  = 5'd7;
  localparam upc_t L_TBOUND = 5'd8;
  localparam upc_t L_TREM   = 5'd9;
  localparam upc_t L_STEPD  = 5'd10;
  localparam upc_t L_DIVOUT = 5'd11;
  localparam upc_t L_DWAIT  = 5'd12;
  localparam upc_t L_DREM   = 5'd13;
  localparam upc_t L_PUSHD  = 5'd14;
  localparam upc_t L_FIN    = 5'd15;
  localparam upc_t L_PREM   = 5'd16;
  localparam upc_t L_FLUSH  = 5'd17;
  localparam upc_t L_ZERO   = 5'd18;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: L_IDLE};
    case (a)
      L_IDLE:   w = '{op: OP_LOAD,      cond: C_NOSTART,  target: L_IDLE};
      L_SMALL:  w = '{op: OP_NOP,       cond: C_LT2,      target: L_ZERO};
      L_PARITY: w = '{op: OP_NOP,       cond: C_ODD,      target: L_SET3};
      L_HALVE:  w = '{op: OP_HALVE,     cond: C_BIT1_CLR, target: L_HALVE};
      L_PUSH2:  w = '{op: OP_PUSH2,     cond: C_NONE,     target: L_IDLE};
      L_SET3:   w = '{op: OP_SET3,      cond: C_NONE,     target: L_IDLE};
      L_TRIAL:  w = '{op: OP_DIV,       cond: C_REM_LE1,  target: L_FIN};
      L_TWAIT:  w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: L_TWAIT};
      L_TBOUND: w = '{op: OP_NOP,       cond: C_D_GT_Q,   target: L_FIN};
      L_TREM:   w = '{op: OP_NOP,       cond: C_R_Z,      target: L_DIVOUT};
      L_STEPD:  w = '{op: OP_STEPD,     cond: C_ALWAYS,   target: L_TRIAL};
      L_DIVOUT: w = '{op: OP_DIVOUT,    cond: C_NONE,     target: L_IDLE};
      L_DWAIT:  w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: L_DWAIT};
      L_DREM:   w = '{op: OP_NOP,       cond: C_R_Z,      target: L_DIVOUT};
      L_PUSHD:  w = '{op: OP_PUSHD,     cond: C_ALWAYS,   target: L_TRIAL};
      L_FIN:    w = '{op: OP_NOP,       cond: C_REM_LE1,  target: L_FLUSH};
      L_PREM:   w = '{op: OP_PUSHREM,   cond: C_NONE,     target: L_IDLE};
      L_FLUSH:  w = '{op: OP_FLUSH,     cond: C_ALWAYS,   target: L_IDLE};
      L_ZERO:   w = '{op: OP_EMIT_ZERO, cond: C_ALWAYS,   target: L_IDLE};
      default:  w = '{op: OP_NOP,       cond: C_ALWAYS,   target: L_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/trial_division_factorizer_unit.sv */
// ----------------------------------------------------------------------------
// trial_division_factorizer_unit: prime factorization by trial division
// Microcoded sequencer over a cofactor register, an odd divisor register and
// a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Drive value and raise start; the transfer happens at an edge where start
//   is high and busy is low. busy then stays high until the run is done.
//   Results leave as (prime, exponent, last) with strobe high for one cycle
//   each, in ascending prime order; last marks the final factor. A value of
//   0 or 1 gives a single result (0, 0, last).
//   Factors of two are removed by shifting the cofactor. Each odd trial
//   divisor runs the one-bit-a-cycle divider over the whole value, and so
//   does every extra division that removes a found factor. Worst case for a
//   32-bit value is about 32768 divisors. One item is handled at a time.
//   Results are registered; one factor is held back so that last can be set
//   on the true final one. The receiver cannot stall the block.
//   Reset (rst, synchronous) returns the sequencer to idle and drops any run.
// ----------------------------------------------------------------------------
module trial_division_factorizer_unit
  import tdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           value,
  output logic                  busy,
  output logic                  strobe,
  output logic [PRIME_BITS-1:0] prime,
  output logic [EXP_BITS-1:0]   exponent,
  output logic                  last
);

  localparam int VB = VALUE_BITS;

  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   jump;

  logic [VB-1:0]       rem;
  logic [VB-1:0]       d;
  logic [E_BITS-1:0]   e;
  logic                has_pend;
  logic [VB-1:0]       pend_prime;
  logic [E_BITS-1:0]   pend_exp;

  // divider: partial remainder, quotient/dividend shifter, step count
  logic [VB-1:0]       div_a;
  logic [VB-1:0]       div_q;
  logic [CNT_BITS-1:0] div_cnt;
  logic                div_busy;
  logic [VB:0]         div_shift;
  logic                div_ge;
  logic [VB-1:0]       div_a_next;

  logic                push;
  logic [VB-1:0]       push_prime;
  logic [E_BITS-1:0]   push_exp;

  assign uw       = ucode(upc);
  assign busy     = (upc != L_IDLE);
  assign div_busy = (div_cnt != '0);

  // Jump condition select
  always_comb begin
    case (uw.cond)
      C_NONE:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NOSTART:  jump = !start;
      C_LT2:      jump = (rem < VB'(2));
      C_ODD:      jump = rem[0];
      C_BIT1_CLR: jump = !rem[1];
      C_REM_LE1:  jump = (rem <= VB'(1));
      C_DIV_BUSY: jump = div_busy;
      C_D_GT_Q:   jump = (d > div_q);
      C_R_Z:      jump = (div_a == '0);
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    upc_next = jump ? uw.target : upc + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= L_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // One restoring division step
  always_comb begin
    div_shift  = {div_a, div_q[VB-1]};
    div_ge     = (div_shift >= {1'b0, d});
    div_a_next = div_ge ? VB'(div_shift - {1'b0, d}) : VB'(div_shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (uw.op == OP_DIV || uw.op == OP_DIVOUT) begin
      div_a   <= '0;
      div_q   <= (uw.op == OP_DIVOUT) ? div_q : rem;
      div_cnt <= CNT_BITS'(VB);
    end else if (div_busy) begin
      div_a   <= div_a_next;
      div_q   <= {div_q[VB-2:0], div_ge};
      div_cnt <= div_cnt - CNT_BITS'(1);
    end
  end

  // Factor to queue behind the pending one
  always_comb begin
    push       = 1'b0;
    push_prime = d;
    push_exp   = e;
    case (uw.op)
      OP_PUSH2: begin
        push       = 1'b1;
        push_prime = VB'(2);
      end
      OP_PUSHD: begin
        push = 1'b1;
      end
      OP_PUSHREM: begin
        push       = 1'b1;
        push_prime = rem;
        push_exp   = E_BITS'(1);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD:   rem <= VB'(value);
      OP_HALVE:  rem <= rem >> 1;
      OP_DIVOUT: rem <= div_q;
      default:   rem <= rem;
    endcase
    case (uw.op)
      OP_LOAD, OP_SET3:   e <= '0;
      OP_HALVE, OP_DIVOUT: e <= e + E_BITS'(1);
      OP_PUSHD:           e <= '0;
      default:            e <= e;
    endcase
    case (uw.op)
      OP_SET3:            d <= VB'(3);
      OP_STEPD, OP_PUSHD: d <= d + VB'(2);
      default:            d <= d;
    endcase
    if (push) begin
      pend_prime <= push_prime;
      pend_exp   <= push_exp;
    end
  end

  // Result register: a new factor releases the held one
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe   <= 1'b0;
      has_pend <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (uw.op == OP_LOAD) begin
        has_pend <= 1'b0;
      end else if (push) begin
        has_pend <= 1'b1;
        if (has_pend) begin
          strobe   <= 1'b1;
          prime    <= PRIME_BITS'(pend_prime);
          exponent <= EXP_BITS'(pend_exp);
          last     <= 1'b0;
        end
      end else if (uw.op == OP_FLUSH) begin
        has_pend <= 1'b0;
        strobe   <= 1'b1;
        prime    <= PRIME_BITS'(pend_prime);
        exponent <= EXP_BITS'(pend_exp);
        last     <= 1'b1;
      end else if (uw.op == OP_EMIT_ZERO) begin
        strobe   <= 1'b1;
        prime    <= '0;
        exponent <= '0;
        last     <= 1'b1;
      end
    end
  end

  a_strobe_in_run: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result outside a run");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer did not start a run");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    strobe && prime == '0 |-> last && exponent == '0)
    else $error("zero prime not a lone final result");

  // the next transfer may be taken in the final result's cycle
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy ##1 !strobe)
    else $error("activity after final result");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the trial-division factorizer
// Feeds unsigned values through the start/busy handshake. A scoreboard works
// out the prime factorization of each accepted value and checks every
// strobed (prime, exponent, last) result against it, in order. A short
// directed set covers the edge values. Random values follow; the costly ones
// are drawn again so that the run stays short.
// ----------------------------------------------------------------------------
module tb_top
  import tdf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS = 100;
  // Odd divisors allowed per random value.
  localparam int          TRIAL_BUDGET = 400;
  // Cycle limit for the whole test; reaching it ends the run with an error.
  localparam int unsigned LIMIT_CYCLES = 8_000_000;
  localparam int          TAIL_CYCLES  = 40;

  localparam int unsigned SMALL_PRIMES [25] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
    53, 59, 61, 67, 71, 73, 79, 83, 89, 97
  };

  localparam logic [31:0] DIRECTED [19] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd15, 32'd25, 32'd49,
    32'd1024, 32'd65521, 32'd16777213, 32'd223092870, 32'd3486784401,
    32'd3221225472, 32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF
  };

  typedef struct packed {
    logic [PRIME_BITS-1:0] prime;
    logic [EXP_BITS-1:0]   exponent;
    logic                  last;
  } factor_t;

  class factor_board;
    factor_t pending[$];
    int      errors;

    // Fill run with the factors of v; return the number of odd divisors tried.
    function int factorise(input logic [31:0] v, output factor_t run[$]);
      longint unsigned rem;
      longint unsigned d;
      longint unsigned e;
      factor_t         f;
      int              tried;
      run   = {};
      tried = 0;
      rem   = 64'(v) & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_BITS));
      if (rem < 2) begin
        f = '{prime: '0, exponent: '0, last: 1'b1};
        run = {run, f};
        return 0;
      end
      if (rem[0] == 1'b0) begin
        e = 0;
        while (rem != 0 && rem[0] == 1'b0) begin
          rem = rem >> 1;
          e++;
        end
        f = '{prime: PRIME_BITS'(2), exponent: e[EXP_BITS-1:0], last: 1'b0};
        run = {run, f};
      end
      d = 3;
      while (rem > 1 && d <= rem / d) begin
        tried++;
        if (rem % d == 0) begin
          e = 0;
          while (rem % d == 0) begin
            rem = rem / d;
            e++;
          end
          f = '{prime: d[PRIME_BITS-1:0], exponent: e[EXP_BITS-1:0], last: 1'b0};
          run = {run, f};
        end
        d += 2;
      end
      // whatever is left above one is itself prime
      if (rem > 1) begin
        f = '{prime: rem[PRIME_BITS-1:0], exponent: EXP_BITS'(1), last: 1'b0};
        run = {run, f};
      end
      run[run.size() - 1].last = 1'b1;
      return tried;
    endfunction

    function void note_value(input logic [31:0] v);
      factor_t run[$];
      void'(factorise(v, run));
      foreach (run[i]) pending = {pending, run[i]};
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_factor(input logic [PRIME_BITS-1:0] p, input logic [EXP_BITS-1:0] e,
                      input logic l);
      factor_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with none due: prime %0d exponent %0d last %b", p, e, l));
        return;
      end
      want = pending.pop_front();
      if (p !== want.prime)
        report($sformatf("prime %0d, want %0d", p, want.prime));
      if (e !== want.exponent)
        report($sformatf("exponent %0d, want %0d (prime %0d)", e, want.exponent, want.prime));
      if (l !== want.last)
        report($sformatf("last %b, want %b (prime %0d)", l, want.last, want.prime));
    endtask
  endclass

  logic                  clk   = 1'b0;
  logic                  rst   = 1'b1;
  logic                  start = 1'b0;
  logic [31:0]           value = '0;
  logic                  busy;
  logic                  strobe;
  logic [PRIME_BITS-1:0] prime;
  logic [EXP_BITS-1:0]   exponent;
  logic                  last;

  factor_board sb = new();
  int unsigned cycle_count = 0;

  trial_division_factorizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .value    (value),
    .busy     (busy),
    .strobe   (strobe),
    .prime    (prime),
    .exponent (exponent),
    .last     (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      sb.check_factor(prime, exponent, last);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Product of a few small primes with a small cofactor, kept within 32 bits.
  function automatic logic [31:0] smooth_value();
    longint unsigned acc;
    longint unsigned p;
    int              n;
    int              j;
    acc = 1;
    n   = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      p = SMALL_PRIMES[$urandom_range(0, 24)];
      for (j = $urandom_range(1, 4); j > 0; j--) begin
        if (acc * p <= 64'hFFFF_FFFF) acc = acc * p;
      end
    end
    p = $urandom_range(1, 1000);
    if (acc * p <= 64'hFFFF_FFFF) acc = acc * p;
    return acc[31:0];
  endfunction

  function automatic logic [31:0] power_value();
    longint unsigned acc;
    longint unsigned p;
    int              n;
    acc = 1;
    p   = SMALL_PRIMES[$urandom_range(0, 24)];
    n   = $urandom_range(1, 31);
    while (n > 0 && acc * p <= 64'hFFFF_FFFF) begin
      acc = acc * p;
      n--;
    end
    return acc[31:0];
  endfunction

  // Draw again until the value needs few enough trial divisions.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    factor_t     run[$];
    int          shape;
    do begin
      shape = $urandom_range(0, 99);
      if (shape < 50)      v = smooth_value();
      else if (shape < 65) v = power_value();
      else if (shape < 80) v = $urandom_range(0, 300);
      else                 v = $urandom >> $urandom_range(0, 20);
    end while (sb.factorise(v, run) > TRIAL_BUDGET);
    return v;
  endfunction

  task automatic send_value(input logic [31:0] v);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_value(v);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      send_value(DIRECTED[i]);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 14));
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // hold off once until the block has nothing left to say
      if (i == RANDOM_ITEMS / 2) wait_all_results();
      send_value(pick_value());
      if (i < RANDOM_ITEMS * 3 / 4 && $urandom_range(0, 2) == 0)
        idle_for($urandom_range(1, 14));
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
